@@ src/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  // slot count and field widths
  localparam int NUM_TIMERS = 16;
  localparam int ID_W       = 4;
  localparam int CNT_W      = 5;
  localparam int TAG_W      = 16;
  localparam int DL_W       = 64;
  localparam int STAMP_W    = 32;
  localparam int TPM_W      = 20;
  localparam int PER_W      = 30;
  localparam int DELTA_W    = 42;
  localparam int TICKS_W    = 32;

  localparam logic [TICKS_W-1:0] MIN_TICKS   = 32'd100;
  localparam logic [DELTA_W-1:0] MAX_DELTA   = 42'd3600000000000;
  localparam logic [DELTA_W-1:0] DUE_DELTA   = 42'd1000;
  localparam logic [20:0]        NS_PER_MS   = 21'd1000000;

  // command codes
  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_TAG    = 3'd2;
  localparam logic [2:0] CMD_RUN    = 3'd3;
  localparam logic [2:0] CMD_ACT    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ARM   = 2'd0;
  localparam logic [1:0] KIND_FIRE  = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  // configuration register indexes
  localparam logic CFG_TPM    = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  timer_id;
    logic [DL_W-1:0]  deadline;
    logic [TAG_W-1:0] owner_tag;
    logic [DL_W-1:0]  now_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    fired_id;
    logic [CNT_W-1:0]   removed;
    logic [TICKS_W-1:0] arm_ticks;
    logic               last;
  } out_item_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic               wr_en;
    logic               clr_en;
    logic [ID_W-1:0]    sel_id;
    logic               drop_en;
    logic [TAG_W-1:0]   tag;
    logic [DL_W-1:0]    deadline;
    logic [STAMP_W-1:0] stamp;
  } cell_ctl_t;

  // running best candidate and tag count handed along the row
  typedef struct packed {
    logic               found;
    logic [DL_W-1:0]    deadline;
    logic [STAMP_W-1:0] stamp;
    logic [ID_W-1:0]    idx;
    logic [CNT_W-1:0]   count;
  } chain_t;

endpackage

`default_nettype wire

@@ src/dtq_cell.sv @@
// ----------------------------------------------------------------------------
// dtq_cell
// One timer slot; merges its entry into the candidate passed down the row.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_cell import dtq_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [ID_W-1:0] cell_idx,
  input  wire cell_ctl_t       ctl,
  input  wire chain_t          chain_in,
  output chain_t               chain_out,
  output logic                 active
);

  logic [DL_W-1:0]    deadline;
  logic [TAG_W-1:0]   tag;
  logic [STAMP_W-1:0] stamp;
  logic               sel;
  logic               take;
  logic               tag_hit;

  assign sel     = (ctl.sel_id == cell_idx);
  assign tag_hit = active && (tag == ctl.tag);

  // active mark
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.wr_en && sel) begin
      active <= 1'b1;
    end else if ((ctl.clr_en && sel) || (ctl.drop_en && tag_hit)) begin
      active <= 1'b0;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (ctl.wr_en && sel) begin
      deadline <= ctl.deadline;
      tag      <= ctl.tag;
      stamp    <= ctl.stamp;
    end
  end

  // earlier deadline wins, equal deadlines by smaller stamp
  assign take = active && (!chain_in.found || (deadline < chain_in.deadline) ||
                ((deadline == chain_in.deadline) && (stamp < chain_in.stamp)));

  // stage towards the neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out.found <= 1'b0;
      chain_out.count <= '0;
    end else begin
      chain_out.found <= chain_in.found | active;
      chain_out.count <= chain_in.count + CNT_W'(tag_hit);
    end
    chain_out.deadline <= take ? deadline : chain_in.deadline;
    chain_out.stamp    <= take ? stamp    : chain_in.stamp;
    chain_out.idx      <= take ? cell_idx : chain_in.idx;
  end

endmodule

`default_nettype wire

@@ src/dtq_arm.sv @@
// ----------------------------------------------------------------------------
// dtq_arm
// Scales a delta in ns to one-shot ticks: multiply, then divide by 1e6 through
// a shift and a reciprocal multiply with a small remainder fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_arm import dtq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DELTA_W-1:0] delta,
  input  wire logic [TPM_W-1:0]   tpm,
  output logic                    done,
  output logic [TICKS_W-1:0]      ticks
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_SUM  = 3'd2;
  localparam logic [2:0] A_CHK  = 3'd3;
  localparam logic [2:0] A_EST  = 3'd4;
  localparam logic [2:0] A_BACK = 3'd5;
  localparam logic [2:0] A_FIX  = 3'd6;
  localparam logic [2:0] A_DONE = 3'd7;

  localparam int NUM_W = DELTA_W + TPM_W;
  // below saturation the product shifted down by 6 fits in 46 bits
  localparam int QUO_W = 46;
  localparam logic [NUM_W-1:0] SAT_LIM = NUM_W'({NS_PER_MS, 32'b0});
  // 1e6 = 64 * 15625; the odd factor goes by floor(2^45 / 15625)
  localparam logic [13:0] ODD_DIV   = 14'd15625;
  localparam logic [31:0] ODD_RECIP = 32'd2251799813;

  logic [2:0]                phase;
  logic [DELTA_W-1:0]        d;
  logic [TPM_W-1:0]          m;
  logic [TPM_W+31:0]         p_lo;
  logic [TPM_W+DELTA_W-33:0] p_hi;
  logic [NUM_W-1:0]          num;
  logic [QUO_W-1:0]          x;
  logic [63:0]               est;
  logic [QUO_W-1:0]          back;
  logic [16:0]               rem;
  logic [2:0]                corr;
  logic [TICKS_W-1:0]        q;

  assign done  = (phase == A_DONE);
  assign ticks = (q < MIN_TICKS) ? MIN_TICKS : q;

  // estimate is at most four short of the true quotient
  assign rem = 17'(x - back);

  always_comb begin
    priority if (rem >= 17'd62500) begin
      corr = 3'd4;
    end else if (rem >= 17'd46875) begin
      corr = 3'd3;
    end else if (rem >= 17'd31250) begin
      corr = 3'd2;
    end else if (rem >= 17'd15625) begin
      corr = 3'd1;
    end else begin
      corr = 3'd0;
    end
  end

  // phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= A_IDLE;
    end else begin
      unique case (phase)
        A_IDLE: if (start) phase <= A_MUL;
        A_MUL:  phase <= A_SUM;
        A_SUM:  phase <= A_CHK;
        A_CHK:  phase <= (num >= SAT_LIM) ? A_DONE : A_EST;
        A_EST:  phase <= A_BACK;
        A_BACK: phase <= A_FIX;
        A_FIX:  phase <= A_DONE;
        A_DONE: phase <= A_IDLE;
        default: phase <= A_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (phase)
      A_IDLE: begin
        if (start) begin
          d <= delta;
          m <= tpm;
        end
      end
      A_MUL: begin
        p_lo <= d[31:0] * m;
        p_hi <= d[DELTA_W-1:32] * m;
      end
      A_SUM: begin
        num <= {p_hi, 32'b0} + NUM_W'(p_lo);
      end
      A_CHK: begin
        q <= '1;
        x <= num[51:6];
      end
      A_EST: begin
        est <= x[QUO_W-1:14] * ODD_RECIP;
      end
      A_BACK: begin
        q    <= est[62:31];
        back <= est[62:31] * ODD_DIV;
      end
      A_FIX: begin
        q <= q + TICKS_W'(corr);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/deadline_timer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// Timer slot queue with least-deadline scan and one-shot count computation.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data, each with last set on the final result of
// a command. One command is handled at a time; in_stall is high from the
// transfer until the sequencer is back in idle. The slots sit in a row of
// cells; the earliest-deadline search and the tag count walk down the row
// one cell per cycle. An arm result goes through launch, the scaler steps
// for the multiply and the reciprocal divide by 1e6 (the estimate steps are
// skipped when it saturates), then the result load. A valid start arms only
// in tickless mode; a cancel or a cancel by tag re-arms when it removed a
// slot in tickless mode; run expired fires each due slot and then re-arms
// when tickless; activate always arms. The output register holds a result
// until it is taken; while out_stall holds it, a step that must load the
// next result waits and the command does not advance. The next command may
// be taken while the final result still waits. Configuration writes
// (cfg_we, cfg_index, cfg_data) are registered.
// Reset (rst, synchronous) empties all slots, clears the stamp counter,
// the periodic tick time and the tickless mark, and loads default config.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_queue_unit import dtq_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_item_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_item_t            out_data,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [PER_W-1:0] cfg_data
);

  localparam int WAIT_W = $clog2(NUM_TIMERS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_CNT  = 3'd3;
  localparam logic [2:0] ST_FIRE = 3'd4;
  localparam logic [2:0] ST_ARM  = 3'd5;
  localparam logic [2:0] ST_ARMW = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [2:0]         ret;
  logic [2:0]         ret_next;
  logic [WAIT_W-1:0]  wait_cnt;
  in_item_t           item;
  logic [TPM_W-1:0]   tpm;
  logic [PER_W-1:0]   period;
  logic [STAMP_W-1:0] stamp_counter;
  logic [DL_W-1:0]    next_tick_time;
  logic               tickless_on;
  logic               was;
  logic               pend_v;
  logic [ID_W-1:0]    pend_id;
  logic [TICKS_W-1:0] arm_ticks;

  cell_ctl_t          ctl;
  chain_t             chain [NUM_TIMERS+1];
  chain_t             tail;
  logic [NUM_TIMERS-1:0] active_vec;

  logic               load;
  out_item_t          load_data;
  logic               can_load;
  logic               id_ok;
  logic               due;
  logic [CNT_W-1:0]   n;
  logic [DL_W-1:0]    target;
  logic [DL_W-1:0]    diff;
  logic [DELTA_W-1:0] delta;
  logic               arm_start;
  logic               arm_done;
  logic [TICKS_W-1:0] arm_result;
  logic               tick_upd;

  assign in_stall = (state != ST_IDLE);
  assign can_load = !out_valid || !out_stall;
  assign tail     = chain[NUM_TIMERS];
  assign id_ok    = ({1'b0, item.timer_id} < (ID_W+1)'(NUM_TIMERS));
  assign due      = tail.found && (tail.deadline <= item.now_ns);
  assign n        = (item.command == CMD_CANCEL) ? CNT_W'(was) : tail.count;

  // row of slot cells
  assign chain[0] = '0;
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    dtq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (ID_W'(i)),
      .ctl       (ctl),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .active    (active_vec[i])
    );
  end

  // one-shot delta from the nearer of earliest slot and periodic tick, or the period on activate
  always_comb begin
    target = next_tick_time;
    if (tail.found && (tail.deadline < next_tick_time)) target = tail.deadline;
    diff = (target > item.now_ns) ? (target - item.now_ns) : DL_W'(DUE_DELTA);
    if (item.command == CMD_ACT) begin
      delta = DELTA_W'(period);
    end else if (diff > DL_W'(MAX_DELTA)) begin
      delta = MAX_DELTA;
    end else begin
      delta = diff[DELTA_W-1:0];
    end
  end

  dtq_arm u_arm (
    .clk   (clk),
    .rst   (rst),
    .start (arm_start),
    .delta (delta),
    .tpm   (tpm),
    .done  (arm_done),
    .ticks (arm_result)
  );

  // sequencer
  always_comb begin
    state_next   = state;
    ret_next     = ret;
    load         = 1'b0;
    load_data    = '0;
    arm_start    = 1'b0;
    tick_upd     = 1'b0;
    ctl          = '0;
    ctl.tag      = item.owner_tag;
    ctl.deadline = item.deadline;
    ctl.stamp    = stamp_counter;
    ctl.sel_id   = item.timer_id;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (item.command)
          CMD_START: begin
            ctl.wr_en  = id_ok;
            state_next = (id_ok && tickless_on) ? ST_WAIT : ST_IDLE;
            ret_next   = ST_ARM;
          end
          CMD_CANCEL: begin
            ctl.clr_en = id_ok;
            state_next = id_ok ? ST_CNT : ST_IDLE;
          end
          CMD_TAG: begin
            state_next = ST_WAIT;
            ret_next   = ST_CNT;
          end
          CMD_RUN: begin
            state_next = ST_WAIT;
            ret_next   = ST_FIRE;
          end
          CMD_ACT: begin
            state_next = ST_ARM;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_WAIT: begin
        if (wait_cnt == WAIT_W'(NUM_TIMERS)) state_next = ret;
      end
      ST_CNT: begin
        if (can_load) begin
          load              = 1'b1;
          load_data.kind    = KIND_COUNT;
          load_data.removed = n;
          load_data.last    = !((n != '0) && tickless_on);
          ctl.drop_en       = (item.command == CMD_TAG);
          state_next        = ((n != '0) && tickless_on) ? ST_WAIT : ST_IDLE;
          ret_next          = ST_ARM;
        end
      end
      ST_FIRE: begin
        if (!pend_v || can_load) begin
          load               = pend_v;
          load_data.kind     = KIND_FIRE;
          load_data.fired_id = pend_id;
          if (due) begin
            ctl.clr_en = 1'b1;
            ctl.sel_id = tail.idx;
            state_next = ST_WAIT;
            ret_next   = ST_FIRE;
          end else begin
            load_data.last = !tickless_on;
            tick_upd       = 1'b1;
            state_next     = tickless_on ? ST_ARM : ST_IDLE;
          end
        end
      end
      ST_ARM: begin
        arm_start  = 1'b1;
        state_next = ST_ARMW;
      end
      ST_ARMW: begin
        if (arm_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (can_load) begin
          load                = 1'b1;
          load_data.kind      = KIND_ARM;
          load_data.arm_ticks = arm_ticks;
          load_data.last      = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ret            <= ST_IDLE;
      wait_cnt       <= '0;
      stamp_counter  <= '0;
      next_tick_time <= '0;
      tickless_on    <= 1'b0;
      pend_v         <= 1'b0;
      out_valid      <= 1'b0;
      tpm            <= 20'd100000;
      period         <= 30'd1000000;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      wait_cnt <= (state == ST_WAIT) ? wait_cnt + WAIT_W'(1) : '0;
      if (ctl.wr_en) stamp_counter <= stamp_counter + STAMP_W'(1);
      if (state == ST_EXEC && item.command == CMD_ACT) begin
        next_tick_time <= item.now_ns + DL_W'(period);
        tickless_on    <= 1'b1;
      end
      if (tick_upd) next_tick_time <= item.now_ns + DL_W'(period);
      // fire held back until it is known whether more follow
      if (state == ST_EXEC) begin
        pend_v <= 1'b0;
      end else if (state == ST_FIRE && (!pend_v || can_load)) begin
        pend_v <= due;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TPM:    tpm    <= cfg_data[TPM_W-1:0];
          CFG_PERIOD: period <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) item <= in_data;
    if (state == ST_EXEC) was <= active_vec[item.timer_id];
    if (state == ST_FIRE && due && (!pend_v || can_load)) pend_id <= tail.idx;
    if (arm_done) arm_ticks <= arm_result;
    if (load) out_data <= load_data;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (load && load_data.kind == KIND_COUNT) |-> load_data.removed <= CNT_W'(NUM_TIMERS))
    else $error("cancel count exceeds slot count");
  a_arm_floor: assert property (@(posedge clk) disable iff (rst)
    (load && load_data.kind == KIND_ARM) |-> load_data.arm_ticks >= MIN_TICKS)
    else $error("arm count below floor");
  a_arm_tickless: assert property (@(posedge clk) disable iff (rst)
    (load && load_data.kind == KIND_ARM && item.command != CMD_ACT) |-> tickless_on)
    else $error("arm result while not tickless");
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.wr_en, ctl.clr_en, ctl.drop_en}))
    else $error("more than one slot action at once");
`endif

endmodule

`default_nettype wire
